// ===== design/joydd_pkg.sv =====
package joydd_pkg;

    // field and register widths
    localparam int AXIS_W   = 8;
    localparam int LEVEL_W  = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W  = 7;

    // datapath widths
    localparam int MAG_W    = 8;   // |axis|, up to 128
    localparam int SQ_W     = 15;  // axis squared, up to 16384
    localparam int SUM_W    = 16;  // x^2 + y^2
    localparam int ROOT_W   = 8;   // floor(sqrt(sum)), up to 181
    localparam int HUND_W   = 15;  // 100 * v
    localparam int DEN_W    = 22;  // full_scale * (x^2 + y^2)
    localparam int Q_W      = 7;   // quotient bits per division pass
    localparam int NUM_W    = DEN_W + Q_W;
    localparam int STEP_W   = 3;

    localparam logic [LEVEL_W-1:0] FULL_DUTY = 7'd100;
    localparam logic [CFG_W-1:0]   FULL_SCALE_RESET = 7'd50;
    localparam logic [CFG_W-1:0]   STOP_RESET = 7'd5;
    localparam logic [SQ_W-1:0]    SQRT_ONE_INIT = 15'h4000;
    localparam logic [STEP_W-1:0]  LAST_STEP = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP       = 1'b1;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_PREP   = 8'b0000_0100,
        ST_SQRT   = 8'b0000_1000,
        ST_MULT1  = 8'b0001_0000,
        ST_MULT2  = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

endpackage

// ===== design/joystick_differential_drive_pwm_unit.sv =====
// Channel | Signals                                  | Dir | Transaction
// --------+------------------------------------------+-----+-----------------------------------
// in      | in_valid, in_ready, command, joy_x, joy_y | in  | joystick sample or one PWM tick
// out     | out_valid, out_ready, left_dir, right_dir,| out | pins and compare levels after item
//         | left_pwm_out, right_pwm_out, left_level,  |     |
//         | right_level                               |     |
// cfg     | cfg_wr_en, cfg_addr, cfg_wdata            | in  | register write, no wait
//
// A sample passes through the bit-serial square root (one root bit per step) and the
// shared restoring divider (two passes of one saturation check plus 7 quotient bits),
// with control states around them. A tick goes straight to the finish state.
// One transaction is in work at a time.
// rst_n is asynchronous, active low; it loads the register defaults and the PWM state.
// A result waits in the output register while the next transaction is accepted;
// the last cycle of an item stalls until that register is free.
module joystick_differential_drive_pwm_unit #(
    parameter int PWM_PERIOD_LIMIT = 100
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic signed [joydd_pkg::AXIS_W-1:0] joy_x,
    input  logic signed [joydd_pkg::AXIS_W-1:0] joy_y,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              left_dir,
    output logic                              right_dir,
    output logic                              left_pwm_out,
    output logic                              right_pwm_out,
    output logic [joydd_pkg::LEVEL_W-1:0]     left_level,
    output logic [joydd_pkg::LEVEL_W-1:0]     right_level,

    input  logic                              cfg_wr_en,
    input  logic [joydd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [joydd_pkg::CFG_W-1:0]       cfg_wdata
);
    import joydd_pkg::*;

    localparam logic [COUNT_W:0] PERIOD_LIMIT = (COUNT_W+1)'(PWM_PERIOD_LIMIT);

    // ---------------- control state ----------------
    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [CFG_W-1:0]     fs_reg, fs_next;
    logic [CFG_W-1:0]     thr_reg, thr_next;
    logic [LEVEL_W-1:0]   left_cmp_reg, left_cmp_next;
    logic [LEVEL_W-1:0]   right_cmp_reg, right_cmp_next;
    logic                 left_dir_reg, left_dir_next;
    logic                 right_dir_reg, right_dir_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [1:0]           pins_reg, pins_next;
    logic                 out_valid_reg, out_valid_next;

    // ---------------- datapath ----------------
    logic                 tick_reg, tick_next;        // item is a PWM tick
    logic                 ab_reg, ab_next;            // quadrant (0,90] or (90,180]
    logic                 unit_left_reg, unit_left_next; // left motor has gain +/-1
    logic                 stop_reg, stop_next;
    logic [MAG_W-1:0]     ax_reg, ax_next;
    logic [MAG_W-1:0]     ay_reg, ay_next;
    logic [SQ_W-1:0]      xx_reg, xx_next;
    logic [SQ_W-1:0]      yy_reg, yy_next;
    logic [SUM_W-1:0]     s_reg, s_next;
    logic [SQ_W-1:0]      num_reg, num_next;
    logic [SUM_W-1:0]     op_reg, op_next;            // square root remainder
    logic [SUM_W-1:0]     root_reg, root_next;
    logic [SQ_W-1:0]      one_reg, one_next;          // current power of four
    logic [DEN_W-1:0]     vn_reg, vn_next;
    logic [HUND_W-1:0]    h_reg, h_next;
    logic [DEN_W-1:0]     dc_reg, dc_next;
    logic [NUM_W-1:0]     nc_reg, nc_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;          // divider remainder
    logic [NUM_W-1:0]     dsh_reg, dsh_next;          // divisor, shifted right each step
    logic [Q_W-1:0]       quo_reg, quo_next;
    logic                 sat_reg, sat_next;
    logic                 sel_reg, sel_next;          // 0 unit-gain pass, 1 cos pass
    logic [LEVEL_W-1:0]   duty_u_reg, duty_u_next;
    logic [LEVEL_W-1:0]   duty_c_reg, duty_c_next;

    // ---------------- output register ----------------
    logic                 o_left_dir_reg, o_left_dir_next;
    logic                 o_right_dir_reg, o_right_dir_next;
    logic                 o_left_pwm_reg, o_left_pwm_next;
    logic                 o_right_pwm_reg, o_right_pwm_next;
    logic [LEVEL_W-1:0]   o_left_lvl_reg, o_left_lvl_next;
    logic [LEVEL_W-1:0]   o_right_lvl_reg, o_right_lvl_next;

    // ---------------- combinational helpers ----------------
    logic                 in_accept;
    logic                 out_free;
    logic                 x_neg, x_zero, y_neg, y_zero, x_pos, y_pos;
    logic                 quad_a, quad_b, quad_c;
    logic [MAG_W-1:0]     ax_in, ay_in;
    logic [CFG_W-1:0]     fs_eff;
    logic [SUM_W-1:0]     sum_w;
    logic [SUM_W:0]       sq_trial;
    logic [ROOT_W-1:0]    v;
    logic [DEN_W:0]       vn_full;
    logic [DEN_W:0]       dc_full;
    logic                 div_ge;
    logic [Q_W-1:0]       q_fin;
    logic [LEVEL_W-1:0]   duty_w;
    logic                 s_zero, c_pos, c_neg, cos_neg, unit_neg;
    logic [LEVEL_W-1:0]   cmp_u, cmp_c;
    logic [COUNT_W:0]     tick_c;
    logic                 tick_wrap;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // quadrant decode, first match wins
    assign x_neg  = joy_x[AXIS_W-1];
    assign y_neg  = joy_y[AXIS_W-1];
    assign x_zero = (joy_x == '0);
    assign y_zero = (joy_y == '0);
    assign x_pos  = !x_neg && !x_zero;
    assign y_pos  = !y_neg && !y_zero;
    assign quad_a = y_pos && !x_neg;
    assign quad_b = x_neg && !y_neg;
    assign quad_c = x_pos || (x_zero && y_zero);

    // magnitude; -128 wraps to 8'h80 = 128, which is what we want
    assign ax_in = x_neg ? MAG_W'(~joy_x + 1'b1) : MAG_W'(joy_x);
    assign ay_in = y_neg ? MAG_W'(~joy_y + 1'b1) : MAG_W'(joy_y);

    assign fs_eff = (fs_reg == '0) ? CFG_W'(1) : fs_reg;

    assign sum_w    = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign sq_trial = {1'b0, root_reg} + {2'b0, one_reg};
    assign v        = root_reg[ROOT_W-1:0];
    assign vn_full  = (DEN_W+1)'(v) * (DEN_W+1)'(num_reg);
    assign dc_full  = (DEN_W+1)'(fs_eff) * (DEN_W+1)'(s_reg);

    assign div_ge = (rem_reg >= dsh_reg);
    assign q_fin  = {quo_reg[Q_W-2:0], div_ge};
    assign duty_w = (sat_reg || (q_fin > FULL_DUTY)) ? FULL_DUTY : q_fin;

    // sign of each gain; zero cos gain counts as not negative
    assign s_zero   = (s_reg == '0);
    assign c_pos    = (xx_reg > yy_reg) || s_zero;
    assign c_neg    = (yy_reg > xx_reg);
    assign cos_neg  = ab_reg ? c_pos : c_neg;   // -cos2t in the upper half, +cos2t below
    assign unit_neg = !ab_reg;
    assign cmp_u    = unit_neg ? duty_u_reg : FULL_DUTY - duty_u_reg;
    assign cmp_c    = cos_neg ? duty_c_reg : FULL_DUTY - duty_c_reg;

    assign tick_c    = {1'b0, count_reg} + 1'b1;
    assign tick_wrap = (tick_c > PERIOD_LIMIT);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        fs_next          = fs_reg;
        thr_next         = thr_reg;
        left_cmp_next    = left_cmp_reg;
        right_cmp_next   = right_cmp_reg;
        left_dir_next    = left_dir_reg;
        right_dir_next   = right_dir_reg;
        count_next       = count_reg;
        pins_next        = pins_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        tick_next        = tick_reg;
        ab_next          = ab_reg;
        unit_left_next   = unit_left_reg;
        stop_next        = stop_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        xx_next          = xx_reg;
        yy_next          = yy_reg;
        s_next           = s_reg;
        num_next         = num_reg;
        op_next          = op_reg;
        root_next        = root_reg;
        one_next         = one_reg;
        vn_next          = vn_reg;
        h_next           = h_reg;
        dc_next          = dc_reg;
        nc_next          = nc_reg;
        rem_next         = rem_reg;
        dsh_next         = dsh_reg;
        quo_next         = quo_reg;
        sat_next         = sat_reg;
        sel_next         = sel_reg;
        duty_u_next      = duty_u_reg;
        duty_c_next      = duty_c_reg;

        o_left_dir_next  = o_left_dir_reg;
        o_right_dir_next = o_right_dir_reg;
        o_left_pwm_next  = o_left_pwm_reg;
        o_right_pwm_next = o_right_pwm_reg;
        o_left_lvl_next  = o_left_lvl_reg;
        o_right_lvl_next = o_right_lvl_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_FULL_SCALE: fs_next  = cfg_wdata;
                CFG_STOP:       thr_next = cfg_wdata;
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    tick_next      = (command == CMD_TICK);
                    ax_next        = ax_in;
                    ay_next        = ay_in;
                    ab_next        = quad_a || quad_b;
                    unit_left_next = quad_a || (!quad_b && !quad_c);
                    stop_next      = (ax_in < {1'b0, thr_reg}) && (ay_in < {1'b0, thr_reg});
                    state_next     = (command == CMD_TICK) ? ST_FINISH : ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                xx_next    = SQ_W'(ax_reg) * SQ_W'(ax_reg);
                yy_next    = SQ_W'(ay_reg) * SQ_W'(ay_reg);
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                s_next     = sum_w;
                num_next   = (xx_reg > yy_reg) ? xx_reg - yy_reg : yy_reg - xx_reg;
                op_next    = sum_w;
                root_next  = '0;
                one_next   = SQRT_ONE_INIT;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                // one root bit per step
                if ({1'b0, op_reg} >= sq_trial)
                begin
                    op_next   = op_reg - sq_trial[SUM_W-1:0];
                    root_next = (root_reg >> 1) + {1'b0, one_reg};
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                one_next = one_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = ST_MULT1;
            end
            ST_MULT1:
            begin
                vn_next    = vn_full[DEN_W-1:0];
                h_next     = HUND_W'(v) * HUND_W'(FULL_DUTY);
                // at the origin v is 0; keep a nonzero divisor
                dc_next    = s_zero ? DEN_W'(fs_eff) : dc_full[DEN_W-1:0];
                state_next = ST_MULT2;
            end
            ST_MULT2:
            begin
                nc_next    = NUM_W'(vn_reg) * NUM_W'(FULL_DUTY);
                rem_next   = NUM_W'(h_reg);
                dsh_next   = NUM_W'({fs_eff, {Q_W{1'b0}}});
                cnt_next   = '0;
                sel_next   = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // step 0 checks for quotient >= 128, steps 1..7 give one bit each
                if (cnt_reg == '0)
                begin
                    sat_next = div_ge;
                    quo_next = '0;
                end
                else
                begin
                    if (div_ge)
                        rem_next = rem_reg - dsh_reg;
                    quo_next = q_fin;
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    if (!sel_reg)
                    begin
                        duty_u_next = duty_w;
                        sel_next    = 1'b1;
                        cnt_next    = '0;
                        rem_next    = nc_reg;
                        dsh_next    = {dc_reg, {Q_W{1'b0}}};
                    end
                    else
                    begin
                        duty_c_next = duty_w;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (tick_reg)
                    begin
                        if (tick_wrap)
                        begin
                            count_next = '0;
                            pins_next  = 2'b11;
                        end
                        else
                        begin
                            count_next = tick_c[COUNT_W-1:0];
                            pins_next  = {({1'b0, right_cmp_reg} > tick_c),
                                          ({1'b0, left_cmp_reg} > tick_c)};
                        end
                    end
                    else
                    begin
                        left_dir_next  = unit_left_reg ? !unit_neg : !cos_neg;
                        right_dir_next = unit_left_reg ? !cos_neg : !unit_neg;
                        if (stop_reg)
                        begin
                            left_cmp_next  = '0;
                            right_cmp_next = '0;
                        end
                        else
                        begin
                            left_cmp_next  = unit_left_reg ? cmp_u : cmp_c;
                            right_cmp_next = unit_left_reg ? cmp_c : cmp_u;
                        end
                    end
                    o_left_dir_next  = left_dir_next;
                    o_right_dir_next = right_dir_next;
                    o_left_pwm_next  = pins_next[0];
                    o_right_pwm_next = pins_next[1];
                    o_left_lvl_next  = left_cmp_next;
                    o_right_lvl_next = right_cmp_next;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fs_reg        <= FULL_SCALE_RESET;
            thr_reg       <= STOP_RESET;
            left_cmp_reg  <= FULL_DUTY;
            right_cmp_reg <= FULL_DUTY;
            left_dir_reg  <= 1'b0;
            right_dir_reg <= 1'b0;
            count_reg     <= '0;
            pins_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fs_reg        <= fs_next;
            thr_reg       <= thr_next;
            left_cmp_reg  <= left_cmp_next;
            right_cmp_reg <= right_cmp_next;
            left_dir_reg  <= left_dir_next;
            right_dir_reg <= right_dir_next;
            count_reg     <= count_next;
            pins_reg      <= pins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg        <= tick_next;
        ab_reg          <= ab_next;
        unit_left_reg   <= unit_left_next;
        stop_reg        <= stop_next;
        ax_reg          <= ax_next;
        ay_reg          <= ay_next;
        xx_reg          <= xx_next;
        yy_reg          <= yy_next;
        s_reg           <= s_next;
        num_reg         <= num_next;
        op_reg          <= op_next;
        root_reg        <= root_next;
        one_reg         <= one_next;
        vn_reg          <= vn_next;
        h_reg           <= h_next;
        dc_reg          <= dc_next;
        nc_reg          <= nc_next;
        rem_reg         <= rem_next;
        dsh_reg         <= dsh_next;
        quo_reg         <= quo_next;
        sat_reg         <= sat_next;
        sel_reg         <= sel_next;
        duty_u_reg      <= duty_u_next;
        duty_c_reg      <= duty_c_next;
        o_left_dir_reg  <= o_left_dir_next;
        o_right_dir_reg <= o_right_dir_next;
        o_left_pwm_reg  <= o_left_pwm_next;
        o_right_pwm_reg <= o_right_pwm_next;
        o_left_lvl_reg  <= o_left_lvl_next;
        o_right_lvl_reg <= o_right_lvl_next;
    end

    assign out_valid     = out_valid_reg;
    assign left_dir      = o_left_dir_reg;
    assign right_dir     = o_right_dir_reg;
    assign left_pwm_out  = o_left_pwm_reg;
    assign right_pwm_out = o_right_pwm_reg;
    assign left_level    = o_left_lvl_reg;
    assign right_level   = o_right_lvl_reg;

    // compare values stay within 0..100
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_cmp_reg <= FULL_DUTY) && (right_cmp_reg <= FULL_DUTY))
        else $error("compare value above full duty");

    // period counter never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} <= PERIOD_LIMIT))
        else $error("period counter beyond limit");

    // one transaction in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // square root is exact floor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULT1) |->
            ((17'(v) * 17'(v)) <= 17'(s_reg)) &&
            (((17'(v) + 17'd1) * (17'(v) + 17'd1)) > 17'(s_reg)))
        else $error("square root result wrong");

    // results only appear from the last cycle of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result without finished transaction");

endmodule
